// ===== design/bpsp_pkg.sv =====
// shared types and constants for the brovey pan-sharpening pixel core
// no dependencies

package bpsp_pkg;

  localparam int MAX_BANDS        = 8;
  localparam int SAMPLE_W         = 16;
  localparam int PROD_W           = 2 * SAMPLE_W;
  localparam int COUNT_W          = 4;
  localparam int DIV_BITS_PER_STG = 4;
  localparam int DIV_STAGES       = SAMPLE_W / DIV_BITS_PER_STG;

  localparam logic [COUNT_W-1:0] BAND_COUNT_RESET = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] BAND_COUNT_MIN   = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] BAND_COUNT_MAX   = COUNT_W'(MAX_BANDS);

  localparam logic [SAMPLE_W-1:0] SAT_POS    = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] SAT_NEG    = 16'h8000;
  localparam logic [SAMPLE_W-1:0] NEG_LIMIT  = 16'h8000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic        [SAMPLE_W-1:0] mag_t;

  typedef struct packed {
    sample_t pan_sample;
    sample_t band_in_0;
    sample_t band_in_1;
    sample_t band_in_2;
    sample_t band_in_3;
    sample_t band_in_4;
    sample_t band_in_5;
    sample_t band_in_6;
    sample_t band_in_7;
  } pix_in_t;

  typedef struct packed {
    sample_t band_out_0;
    sample_t band_out_1;
    sample_t band_out_2;
    sample_t band_out_3;
    sample_t band_out_4;
    sample_t band_out_5;
    sample_t band_out_6;
    sample_t band_out_7;
  } pix_out_t;

endpackage

// ===== design/brovey_pan_sharpen_pixel_core.sv =====
// brovey pan-sharpening pixel core: pipelined band sum, products and division
// depends on bpsp_pkg

// One pixel word enters per cycle unless a stalled output word holds the
// pipeline. Stages: input register, band sum and eight 16x16 products,
// magnitudes and overflow check, then four restoring-division stages of 4
// quotient bits each, then sign, saturation and the output register. Each
// band is pan * band / sum, truncated toward zero and saturated to signed 16
// bits; the sum wraps at 16 bits, a zero sum gives all zeros and bands at or
// above band_count give zero. band_count (1..8, reset 3, 0 reads as 1, above
// 8 reads as 8) is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while no pixel is in flight; the block does not enforce it.
// A stall on a valid output word holds the whole pipeline.
module brovey_pan_sharpen_pixel_core
  import bpsp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [COUNT_W-1:0]  cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  pix_in_t             in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output pix_out_t            out_word
);

  logic [COUNT_W-1:0] band_count_r;
  logic [COUNT_W-1:0] act_cnt;
  logic               adv;

  // stage a
  logic    a_vld_r;
  pix_in_t a_word_r;
  sample_t a_band [MAX_BANDS];

  // stage b
  logic                 b_vld_r;
  prod_t                b_prod_r [MAX_BANDS];
  prod_t                b_prod_nxt [MAX_BANDS];
  sample_t              b_sum_r;
  sample_t              b_sum_nxt;
  logic [MAX_BANDS-1:0] b_mask_r;
  logic [MAX_BANDS-1:0] b_mask_nxt;

  // division pipe, index 0 is the setup stage
  logic                 d_vld_r  [DIV_STAGES+1];
  mag_t                 d_div_r  [DIV_STAGES+1];
  logic                 d_zero_r [DIV_STAGES+1];
  logic [MAX_BANDS-1:0] d_mask_r [DIV_STAGES+1];
  logic [MAX_BANDS-1:0] d_neg_r  [DIV_STAGES+1];
  logic [MAX_BANDS-1:0] d_ovf_r  [DIV_STAGES+1];
  mag_t                 d_rem_r  [DIV_STAGES+1][MAX_BANDS];
  mag_t                 d_quo_r  [DIV_STAGES+1][MAX_BANDS];

  mag_t                 c_div_nxt;
  logic [MAX_BANDS-1:0] c_neg_nxt;
  logic [MAX_BANDS-1:0] c_ovf_nxt;
  mag_t                 c_rem_nxt [MAX_BANDS];
  mag_t                 c_quo_nxt [MAX_BANDS];
  mag_t                 s_rem_nxt [DIV_STAGES][MAX_BANDS];
  mag_t                 s_quo_nxt [DIV_STAGES][MAX_BANDS];

  // output
  logic     out_valid_r;
  pix_out_t out_word_r;
  pix_out_t out_word_nxt;
  sample_t  res [MAX_BANDS];

  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_count_r <= BAND_COUNT_RESET;
    end else if (cfg_wr_en) begin
      band_count_r <= cfg_wr_data;
    end
  end

  always_comb begin
    priority if (band_count_r < BAND_COUNT_MIN) begin
      act_cnt = BAND_COUNT_MIN;
    end else if (band_count_r > BAND_COUNT_MAX) begin
      act_cnt = BAND_COUNT_MAX;
    end else begin
      act_cnt = band_count_r;
    end
  end

  assign a_band[0] = a_word_r.band_in_0;
  assign a_band[1] = a_word_r.band_in_1;
  assign a_band[2] = a_word_r.band_in_2;
  assign a_band[3] = a_word_r.band_in_3;
  assign a_band[4] = a_word_r.band_in_4;
  assign a_band[5] = a_word_r.band_in_5;
  assign a_band[6] = a_word_r.band_in_6;
  assign a_band[7] = a_word_r.band_in_7;

  // wrapped band sum and products
  always_comb begin
    sample_t acc;
    acc = '0;
    for (int k = 0; k < MAX_BANDS; k++) begin
      b_mask_nxt[k] = (COUNT_W'(k) < act_cnt);
      b_prod_nxt[k] = PROD_W'(a_band[k]) * PROD_W'(a_word_r.pan_sample);
      if (b_mask_nxt[k]) begin
        acc = acc + a_band[k];
      end
    end
    b_sum_nxt = acc;
  end

  // magnitudes, signs and quotient overflow
  always_comb begin
    prod_t pm;
    c_div_nxt = b_sum_r[SAMPLE_W-1] ? mag_t'(-b_sum_r) : mag_t'(b_sum_r);
    for (int k = 0; k < MAX_BANDS; k++) begin
      pm           = b_prod_r[k][PROD_W-1] ? -b_prod_r[k] : b_prod_r[k];
      c_neg_nxt[k] = b_prod_r[k][PROD_W-1] ^ b_sum_r[SAMPLE_W-1];
      c_ovf_nxt[k] = (pm[PROD_W-1:SAMPLE_W] >= c_div_nxt);
      c_rem_nxt[k] = pm[PROD_W-1:SAMPLE_W];
      c_quo_nxt[k] = pm[SAMPLE_W-1:0];
    end
  end

  // restoring division, quotient bits shift into the low end
  always_comb begin
    mag_t                r;
    mag_t                q;
    logic [SAMPLE_W:0]   t;
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int k = 0; k < MAX_BANDS; k++) begin
        r = d_rem_r[s][k];
        q = d_quo_r[s][k];
        for (int j = 0; j < DIV_BITS_PER_STG; j++) begin
          t = {r, q[SAMPLE_W-1]};
          q = {q[SAMPLE_W-2:0], 1'b0};
          if (t >= {1'b0, d_div_r[s]}) begin
            t    = t - {1'b0, d_div_r[s]};
            q[0] = 1'b1;
          end
          r = t[SAMPLE_W-1:0];
        end
        s_rem_nxt[s][k] = r;
        s_quo_nxt[s][k] = q;
      end
    end
  end

  // sign, saturation, zero sum and inactive bands
  always_comb begin
    mag_t q;
    for (int k = 0; k < MAX_BANDS; k++) begin
      q = d_quo_r[DIV_STAGES][k];
      priority if (d_zero_r[DIV_STAGES] || !d_mask_r[DIV_STAGES][k]) begin
        res[k] = '0;
      end else if (d_neg_r[DIV_STAGES][k]) begin
        if (d_ovf_r[DIV_STAGES][k] || (q > NEG_LIMIT)) begin
          res[k] = SAT_NEG;
        end else begin
          res[k] = -q;
        end
      end else begin
        if (d_ovf_r[DIV_STAGES][k] || q[SAMPLE_W-1]) begin
          res[k] = SAT_POS;
        end else begin
          res[k] = q;
        end
      end
    end
    out_word_nxt.band_out_0 = res[0];
    out_word_nxt.band_out_1 = res[1];
    out_word_nxt.band_out_2 = res[2];
    out_word_nxt.band_out_3 = res[3];
    out_word_nxt.band_out_4 = res[4];
    out_word_nxt.band_out_5 = res[5];
    out_word_nxt.band_out_6 = res[6];
    out_word_nxt.band_out_7 = res[7];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int s = 0; s <= DIV_STAGES; s++) begin
        d_vld_r[s] <= 1'b0;
      end
    end else if (adv) begin
      a_vld_r    <= in_valid;
      b_vld_r    <= a_vld_r;
      d_vld_r[0] <= b_vld_r;
      for (int s = 0; s < DIV_STAGES; s++) begin
        d_vld_r[s+1] <= d_vld_r[s];
      end
      out_valid_r <= d_vld_r[DIV_STAGES];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      a_word_r    <= in_word;
      b_sum_r     <= b_sum_nxt;
      b_mask_r    <= b_mask_nxt;
      d_div_r[0]  <= c_div_nxt;
      d_zero_r[0] <= (b_sum_r == '0);
      d_mask_r[0] <= b_mask_r;
      d_neg_r[0]  <= c_neg_nxt;
      d_ovf_r[0]  <= c_ovf_nxt;
      for (int k = 0; k < MAX_BANDS; k++) begin
        b_prod_r[k]   <= b_prod_nxt[k];
        d_rem_r[0][k] <= c_rem_nxt[k];
        d_quo_r[0][k] <= c_quo_nxt[k];
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
        d_div_r[s+1]  <= d_div_r[s];
        d_zero_r[s+1] <= d_zero_r[s];
        d_mask_r[s+1] <= d_mask_r[s];
        d_neg_r[s+1]  <= d_neg_r[s];
        d_ovf_r[s+1]  <= d_ovf_r[s];
        for (int k = 0; k < MAX_BANDS; k++) begin
          d_rem_r[s+1][k] <= s_rem_nxt[s][k];
          d_quo_r[s+1][k] <= s_quo_nxt[s][k];
        end
      end
      out_word_r <= out_word_nxt;
    end
  end

`ifndef SYNTHESIS
  // a free output side never pushes back on the input
  assert property (@(posedge clk) disable iff (!rst_n) !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // a pixel with a zero band sum leaves as all zeros
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && d_vld_r[DIV_STAGES] && d_zero_r[DIV_STAGES]) |=> (out_word == '0))
    else $error("zero band sum gave a nonzero word");

  // the last division stage reaches the output when the pipe moves
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && d_vld_r[DIV_STAGES]) |=> out_valid)
    else $error("word lost between division and output");
`endif

endmodule
